@@ rtl/trilinear_cic_deposit_assert.svh @@
// Assertion macros for the trilinear cloud-in-cell deposit block.
// Used by the top level; needs no package.
`ifndef TRILINEAR_CIC_DEPOSIT_ASSERT_SVH
`define TRILINEAR_CIC_DEPOSIT_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define TCD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define TCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tcd_pkg.sv @@
// Shared types, constants and helper functions of the trilinear deposit block.
// No dependencies; every RTL module imports it.
package tcd_pkg;

    // Field widths
    localparam int NODE_W   = 10;
    localparam int GS_W     = NODE_W + 1;
    localparam int FRAC_BITS = 16;
    localparam int FACT_W   = FRAC_BITS + 1;
    localparam int CHARGE_W = 24;
    localparam int CORNER_W = 3;

    // Grid constants
    localparam logic [GS_W-1:0]   GRID_MAX   = 11'd1024;
    localparam logic [GS_W-1:0]   GRID_RESET = 11'd64;
    localparam logic [FACT_W-1:0] FRAC_ONE   = 17'h10000;

    // Remainder unit: two bits of the cell coordinate per cycle
    localparam int DIV_CYCLES = NODE_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

    localparam logic [CORNER_W-1:0] CORNER_FIRST = 3'd0;
    localparam logic [CORNER_W-1:0] CORNER_LAST  = 3'd7;

    localparam int Q_DEPTH_DEF = 4;

    typedef struct packed {
        logic [NODE_W-1:0]          cell_x;
        logic [NODE_W-1:0]          cell_y;
        logic [NODE_W-1:0]          cell_z;
        logic [FRAC_BITS-1:0]       frac_x;
        logic [FRAC_BITS-1:0]       frac_y;
        logic [FRAC_BITS-1:0]       frac_z;
        logic signed [CHARGE_W-1:0] charge;
        logic                       final_particle;
    } t_in_word;

    typedef struct packed {
        logic [NODE_W-1:0]          node_x;
        logic [NODE_W-1:0]          node_y;
        logic [NODE_W-1:0]          node_z;
        logic signed [CHARGE_W-1:0] share;
        logic [CORNER_W-1:0]        corner;
        logic                       last_corner;
        logic                       batch_end;
    } t_out_word;

    // One classified particle waiting for the corner sequencer
    typedef struct packed {
        logic [NODE_W-1:0]          base_x;
        logic [NODE_W-1:0]          base_y;
        logic [NODE_W-1:0]          base_z;
        logic [NODE_W-1:0]          inc_x;
        logic [NODE_W-1:0]          inc_y;
        logic [NODE_W-1:0]          inc_z;
        logic [FRAC_BITS-1:0]       frac_x;
        logic [FRAC_BITS-1:0]       frac_y;
        logic [FRAC_BITS-1:0]       frac_z;
        logic signed [CHARGE_W-1:0] charge;
        logic                       final_particle;
    } t_job;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIVIDE,
        FR_PUSH
    } t_front_state;

    // Map a zero or oversized grid size onto the largest grid
    function automatic logic [GS_W-1:0] eff_grid(input logic [GS_W-1:0] gs);
        if (gs == '0 || gs > GRID_MAX) begin
            return GRID_MAX;
        end
        return gs;
    endfunction

    // One restoring remainder step: shift in a bit, subtract if it fits
    function automatic logic [NODE_W-1:0] mod_step(input logic [NODE_W-1:0] r,
                                                    input logic b,
                                                    input logic [GS_W-1:0] gs);
        logic [GS_W-1:0] t;
        t = {r, b};
        if (t >= gs) begin
            t = t - gs;
        end
        return t[NODE_W-1:0];
    endfunction

    // Next node along an axis, wrapping to zero at the grid size
    function automatic logic [NODE_W-1:0] step_up(input logic [NODE_W-1:0] base,
                                                   input logic [GS_W-1:0] gs);
        logic [GS_W-1:0] t;
        t = {1'b0, base} + GS_W'(1);
        if (t == gs) begin
            t = '0;
        end
        return t[NODE_W-1:0];
    endfunction

    // Axis factor: fraction for the far node, complement for the near one
    function automatic logic [FACT_W-1:0] axis_factor(input logic [FRAC_BITS-1:0] f,
                                                       input logic bit_sel);
        if (bit_sel) begin
            return {1'b0, f};
        end
        return FRAC_ONE - {1'b0, f};
    endfunction

endpackage

@@ rtl/tcd_front.sv @@
// Front end: accepts particle words, reduces cell coordinates modulo the grid size
// and pushes classified jobs into the queue. Depends on tcd_pkg.
module tcd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tcd_pkg::GS_W-1:0]      i_grid_size,
    input  logic                          i_in_valid,
    input  tcd_pkg::t_in_word             i_in_data,
    output logic                          o_in_stall,
    output logic                          o_push,
    output tcd_pkg::t_job                 o_job,
    input  logic                          i_full
);
    import tcd_pkg::*;

    t_front_state           r_state, n_state;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [NODE_W-1:0]      r_sh_x, r_sh_y, r_sh_z;
    logic [NODE_W-1:0]      r_rem_x, r_rem_y, r_rem_z;
    logic [GS_W-1:0]        r_gs;
    t_in_word               r_item;
    logic                   accept;
    logic [NODE_W-1:0]      mid_x, mid_y, mid_z;
    logic [NODE_W-1:0]      n_rem_x, n_rem_y, n_rem_z;

    // Two remainder steps per cycle on each axis
    always_comb begin
        mid_x   = mod_step(r_rem_x, r_sh_x[NODE_W-1], r_gs);
        mid_y   = mod_step(r_rem_y, r_sh_y[NODE_W-1], r_gs);
        mid_z   = mod_step(r_rem_z, r_sh_z[NODE_W-1], r_gs);
        n_rem_x = mod_step(mid_x, r_sh_x[NODE_W-2], r_gs);
        n_rem_y = mod_step(mid_y, r_sh_y[NODE_W-2], r_gs);
        n_rem_z = mod_step(mid_z, r_sh_z[NODE_W-2], r_gs);
    end

    // Next state and handshake
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_push     = 1'b0;
        unique case (r_state)
            FR_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = FR_DIVIDE;
                end
            end
            FR_DIVIDE: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = FR_PUSH;
                end
            end
            FR_PUSH: begin
                o_in_stall = i_full;
                o_push     = !i_full;
                if (!i_full) begin
                    n_state = i_in_valid ? FR_DIVIDE : FR_IDLE;
                end
            end
            default: begin
                n_state = FR_IDLE;
            end
        endcase
    end

    assign accept = i_in_valid && !o_in_stall;

    // Hold state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cnt <= '0;
            end else if (r_state == FR_DIVIDE) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
            end
        end
    end

    // Load a new word, then shift cell bits through the remainder unit
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item  <= i_in_data;
            r_gs    <= eff_grid(i_grid_size);
            r_sh_x  <= i_in_data.cell_x;
            r_sh_y  <= i_in_data.cell_y;
            r_sh_z  <= i_in_data.cell_z;
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_rem_z <= '0;
        end else if (r_state == FR_DIVIDE) begin
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_rem_z <= n_rem_z;
            r_sh_x  <= {r_sh_x[NODE_W-3:0], 2'b00};
            r_sh_y  <= {r_sh_y[NODE_W-3:0], 2'b00};
            r_sh_z  <= {r_sh_z[NODE_W-3:0], 2'b00};
        end
    end

    // Assemble the job: base nodes and their wrapped neighbors
    always_comb begin
        o_job.base_x         = r_rem_x;
        o_job.base_y         = r_rem_y;
        o_job.base_z         = r_rem_z;
        o_job.inc_x          = step_up(r_rem_x, r_gs);
        o_job.inc_y          = step_up(r_rem_y, r_gs);
        o_job.inc_z          = step_up(r_rem_z, r_gs);
        o_job.frac_x         = r_item.frac_x;
        o_job.frac_y         = r_item.frac_y;
        o_job.frac_z         = r_item.frac_z;
        o_job.charge         = r_item.charge;
        o_job.final_particle = r_item.final_particle;
    end

endmodule

@@ rtl/tcd_queue.sv @@
// Short job queue between the front end and the corner sequencer.
// Depends on tcd_pkg for the job type.
module tcd_queue #(
    parameter int DEPTH = tcd_pkg::Q_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcd_pkg::t_job  i_job,
    output logic           o_full,
    output logic           o_valid,
    output tcd_pkg::t_job  o_job,
    input  logic           i_pop
);
    import tcd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/tcd_back.sv @@
// Back end: walks the eight corners of the head job and computes each share
// through a three-multiplier pipeline into the output register. Depends on tcd_pkg.
module tcd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  tcd_pkg::t_job       i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    output tcd_pkg::t_out_word  o_out_data,
    input  logic                i_out_stall
);
    import tcd_pkg::*;

    localparam int AB_W   = 2 * FACT_W;
    localparam int PROD_W = CHARGE_W + FACT_W;

    logic [CORNER_W-1:0]        r_k;
    logic                       en, issue;
    logic [FACT_W-1:0]          fa, fb, fc;
    t_out_word                  meta;

    logic                       r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic [AB_W-1:0]            r_s1_ab;
    logic [FACT_W-1:0]          r_s1_c;
    logic signed [CHARGE_W-1:0] r_s1_q, r_s2_q;
    t_out_word                  r_s1_meta, r_s2_meta, r_s3_meta, r_out_data;
    logic [AB_W-1:0]            r_s2_w3;
    logic signed [PROD_W-1:0]   r_s3_prod;
    logic [FACT_W-1:0]          w2, w3;
    t_out_word                  s3_word;

    // Advance the whole pipeline whenever the output register frees up
    assign en    = !r_out_valid || !i_out_stall;
    assign issue = en && i_q_valid;
    assign o_pop = issue && (r_k == CORNER_LAST);

    // Select factors and node coordinates for the current corner
    always_comb begin
        fa               = axis_factor(i_job.frac_x, r_k[2]);
        fb               = axis_factor(i_job.frac_y, r_k[1]);
        fc               = axis_factor(i_job.frac_z, r_k[0]);
        meta.node_x      = r_k[2] ? i_job.inc_x : i_job.base_x;
        meta.node_y      = r_k[1] ? i_job.inc_y : i_job.base_y;
        meta.node_z      = r_k[0] ? i_job.inc_z : i_job.base_z;
        meta.share       = '0;
        meta.corner      = r_k;
        meta.last_corner = (r_k == CORNER_LAST);
        meta.batch_end   = (r_k == CORNER_LAST) && i_job.final_particle;
        w2               = r_s1_ab[FRAC_BITS +: FACT_W];
        w3               = r_s2_w3[FRAC_BITS +: FACT_W];
        s3_word          = r_s3_meta;
        s3_word.share    = r_s3_prod[FRAC_BITS +: CHARGE_W];
    end

    // Hold corner counter and stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= CORNER_FIRST;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            if (i_q_valid) begin
                r_k <= r_k + CORNER_W'(1);
            end
            r_s1_valid  <= i_q_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    // Multiply: x by y factor, then by z factor, then by the charge
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ab    <= AB_W'(fa) * AB_W'(fb);
            r_s1_c     <= fc;
            r_s1_q     <= i_job.charge;
            r_s1_meta  <= meta;

            r_s2_w3    <= AB_W'(w2) * AB_W'(r_s1_c);
            r_s2_q     <= r_s1_q;
            r_s2_meta  <= r_s1_meta;

            r_s3_prod  <= PROD_W'(r_s2_q) * PROD_W'(signed'({1'b0, w3}));
            r_s3_meta  <= r_s2_meta;

            r_out_data <= s3_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ rtl/trilinear_cic_deposit.sv @@
// After acceptance a particle runs through the remainder unit, the job queue and the
// multiplier pipeline into the output register. Throughput: eight result words per
// particle at one per cycle while the output is not stalled, set by the corner sequencer.
// Reset: synchronous, active low; clears the queue and pipeline, grid size goes to 64.
// Top level: holds the grid size register and joins front end, queue and back end.
// Depends on tcd_pkg, tcd_front, tcd_queue, tcd_back and the assertion header.
`include "trilinear_cic_deposit_assert.svh"

module trilinear_cic_deposit #(
    parameter int QUEUE_DEPTH = tcd_pkg::Q_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [tcd_pkg::GS_W-1:0]    i_cfg_data,
    output logic                        o_cfg_ready,
    input  logic                        i_in_valid,
    input  tcd_pkg::t_in_word           i_in_data,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output tcd_pkg::t_out_word          o_out_data,
    input  logic                        i_out_stall
);
    import tcd_pkg::*;

    logic [GS_W-1:0] r_grid_size;
    logic            w_push, w_full, w_q_valid, w_pop;
    t_job            w_push_job, w_head_job;

    // Take configuration words at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_grid_size <= i_cfg_data;
        end
    end

    tcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grid_size (r_grid_size),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_push      (w_push),
        .o_job       (w_push_job),
        .i_full      (w_full)
    );

    tcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_job   (w_head_job),
        .i_pop   (w_pop)
    );

    tcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // Front end never pushes into a full queue
    `TCD_ASSERT_SAME(a_push_not_full, i_clk, i_rst_n, w_push, !w_full, "push into full queue")

    // Last-corner flag only on the eighth corner
    `TCD_ASSERT_SAME(a_last_corner, i_clk, i_rst_n, o_out_valid && o_out_data.last_corner,
        o_out_data.corner == CORNER_LAST, "last_corner on wrong corner")

    // Batch end only together with the last corner
    `TCD_ASSERT_SAME(a_batch_end, i_clk, i_rst_n, o_out_valid && o_out_data.batch_end,
        o_out_data.last_corner, "batch_end without last_corner")

    // Popping a job means the sequencer moves on to corner zero
    `TCD_ASSERT_NEXT(a_pop_wraps, i_clk, i_rst_n, w_pop,
        u_back.r_k == CORNER_FIRST, "corner counter not wrapped after pop")

endmodule
